// ===== rtl/core/sukq_pkg.sv =====
// Shared types and constants for the sorted unique key queue.
package sukq_pkg;

	localparam int KEY_W        = 64;
	localparam int ACT_W        = 2;
	localparam int STAT_W       = 2;
	localparam int DEF_DEPTH    = 16;
	localparam int DEF_KEY_BITS = 64;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH  = 2'd0,
		ACT_POP   = 2'd1,
		ACT_PEEK  = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// controller -> datapath commands
	typedef struct packed {
		logic ready;
		logic cap;
		logic cmp;
		logic exec;
	} ctl_t;

	// datapath/top -> controller status
	typedef struct packed {
		logic in_valid;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/sukq_if.sv =====
// Request and response channel interfaces of the sorted unique key queue.
interface sukq_req_if
	import sukq_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [KEY_W-1:0]   key;
	logic               tag;

	modport source (output valid, action, key, tag, input ready);
	modport sink   (input valid, action, key, tag, output ready);
endinterface

interface sukq_rsp_if
	import sukq_pkg::*;
#(
	parameter int CNT_W = 5
) ();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [KEY_W-1:0]   head_key;
	logic               head_tag;
	logic [CNT_W-1:0]   occupancy;
	logic               is_empty;

	modport source (output valid, status, head_key, head_tag, occupancy, is_empty,
		input ready);
	modport sink   (input valid, status, head_key, head_tag, occupancy, is_empty,
		output ready);
endinterface

// ===== rtl/core/sukq_datapath.sv =====
// Datapath: command register, sorted cell array with compare vectors, result register.
module sukq_datapath
	import sukq_pkg::*;
#(
	parameter int DEPTH    = DEF_DEPTH,
	parameter int KEY_BITS = DEF_KEY_BITS,
	localparam int CW      = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  logic [ACT_W-1:0]  in_action,
	input  logic [KEY_W-1:0]  in_key,
	input  logic              in_tag,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              out_free,
	output status_t           out_status,
	output logic [KEY_W-1:0]  out_head_key,
	output logic              out_head_tag,
	output logic [CW-1:0]     out_occupancy,
	output logic              out_is_empty
);

	// command register
	action_t               act_q;
	logic [KEY_BITS-1:0]   key_q;
	logic                  tag_q;

	// cell array
	logic [KEY_BITS-1:0]   keys_q [DEPTH];
	logic [DEPTH-1:0]      tags_q;
	logic [DEPTH-1:0]      valid_q;
	logic [CW-1:0]         count_q;

	// per-cell compare results
	logic [DEPTH-1:0]      lt_s1;
	logic [DEPTH-1:0]      eq_s1;

	// result register
	logic                  out_valid_q;
	status_t               res_status_q;
	logic [KEY_W-1:0]      res_key_q;
	logic                  res_tag_q;
	logic [CW-1:0]         res_cnt_q;

	logic                  dup, full, empty;
	logic                  do_push, do_pop, show_head;
	status_t               res_status;
	logic [CW-1:0]         next_cnt;

	// decode the command against the compare vectors
	assign dup       = |eq_s1;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = ctl.exec && (act_q == ACT_PUSH) && !dup && !full;
	assign do_pop    = ctl.exec && (act_q == ACT_POP) && !empty;
	assign show_head = ((act_q == ACT_POP) || (act_q == ACT_PEEK)) && !empty;

	always_comb begin
		res_status = ST_OK;
		next_cnt   = count_q;
		case (act_q)
			ACT_PUSH: begin
				if (dup)
					res_status = ST_DUP;
				else if (full)
					res_status = ST_FULL;
				else
					next_cnt = count_q + CW'(1);
			end
			ACT_POP: begin
				if (empty)
					res_status = ST_EMPTY;
				else
					next_cnt = count_q - CW'(1);
			end
			ACT_PEEK: begin
				if (empty)
					res_status = ST_EMPTY;
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	// command capture, compare, cell updates and result register
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			act_q <= action_t'(in_action);
			key_q <= in_key[KEY_BITS-1:0];
			tag_q <= in_tag;
		end
		if (ctl.cmp) begin
			for (int i = 0; i < DEPTH; i++) begin
				lt_s1[i] <= valid_q[i] && (keys_q[i] < key_q);
				eq_s1[i] <= valid_q[i] && (keys_q[i] == key_q);
			end
		end
		if (do_push) begin
			// cell 0 takes the new key unless it holds a smaller one
			if (!lt_s1[0]) begin
				keys_q[0] <= key_q;
				tags_q[0] <= tag_q;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (!lt_s1[i]) begin
					if (lt_s1[i-1]) begin
						keys_q[i] <= key_q;
						tags_q[i] <= tag_q;
					end else begin
						keys_q[i] <= keys_q[i-1];
						tags_q[i] <= tags_q[i-1];
					end
				end
			end
		end
		if (do_pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				keys_q[i] <= keys_q[i+1];
				tags_q[i] <= tags_q[i+1];
			end
		end
		if (ctl.exec) begin
			res_status_q <= res_status;
			res_key_q    <= show_head ? KEY_W'(keys_q[0]) : '0;
			res_tag_q    <= show_head ? tags_q[0] : 1'b0;
			res_cnt_q    <= next_cnt;
		end
	end

	// occupancy, valid bits and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_push) begin
				valid_q <= {valid_q[DEPTH-2:0], 1'b1};
				count_q <= next_cnt;
			end else if (do_pop) begin
				valid_q <= {1'b0, valid_q[DEPTH-1:1]};
				count_q <= next_cnt;
			end
			if (ctl.exec)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_free      = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_status    = res_status_q;
	assign out_head_key  = res_key_q;
	assign out_head_tag  = res_tag_q;
	assign out_occupancy = res_cnt_q;
	assign out_is_empty  = (res_cnt_q == '0);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("valid bits disagree with occupancy");

	a_exec_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before taken");

endmodule

// ===== rtl/core/sukq_ctrl.sv =====
// Controller: sequences capture, compare and update of each request beat.
module sukq_ctrl
	import sukq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC
	} state_t;

	state_t state_q;

	// a new beat is taken when idle or while the current one retires
	always_comb begin
		ctl.exec  = (state_q == S_EXEC) && sts.out_free;
		ctl.ready = (state_q == S_IDLE) || ctl.exec;
		ctl.cap   = ctl.ready && sts.in_valid;
		ctl.cmp   = (state_q == S_CMP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.cap)
						state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (ctl.exec)
						state_q <= ctl.cap ? S_CMP : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cap_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cap |=> ctl.cmp)
		else $error("captured beat not compared next cycle");

	a_cmp_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmp |=> (state_q == S_EXEC))
		else $error("compare not followed by update");

	a_no_cap_in_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmp |-> !ctl.ready)
		else $error("beat accepted during compare");

endmodule

// ===== rtl/core/sorted_unique_key_queue.sv =====
// A request beat is captured in the command register, compared against all cells into
// the compare vectors, then updates the shift-cell array and the result register; a stalled
// result holds the update. A new beat is accepted while the current one is updated.
// Reset (arst_n low, asynchronous) empties the queue and clears all control state;
// entry storage is not cleared and no clearing pass runs.
module sorted_unique_key_queue
	import sukq_pkg::*;
#(
	parameter int DEPTH    = DEF_DEPTH,
	parameter int KEY_BITS = DEF_KEY_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	sukq_req_if.sink    req,
	sukq_rsp_if.source  rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	ctl_t            ctl;
	sts_t            sts;
	logic            out_free;
	status_t         status;
	logic [CW-1:0]   occupancy;

	assign sts.in_valid = req.valid;
	assign sts.out_free = out_free;
	assign req.ready    = ctl.ready;

	sukq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	sukq_datapath #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.in_action     (req.action),
		.in_key        (req.key),
		.in_tag        (req.tag),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.out_free      (out_free),
		.out_status    (status),
		.out_head_key  (rsp.head_key),
		.out_head_tag  (rsp.head_tag),
		.out_occupancy (occupancy),
		.out_is_empty  (rsp.is_empty)
	);

	assign rsp.status    = status;
	assign rsp.occupancy = occupancy;

endmodule

// ===== bench/sorted_unique_key_queue_tb.sv =====
// Self-checking testbench for the sorted unique key queue: directed table, then random traffic.
`timescale 1ns / 100ps

module sorted_unique_key_queue_tb;
	import sukq_pkg::*;

	localparam int QDEPTH        = DEF_DEPTH;
	localparam int CNT_W         = 5;
	localparam int N_DIRECTED    = 25;
	localparam int N_RANDOM      = 1600;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 20;
	localparam int LONG_HOLD     = 300;
	localparam int HOLD_AFTER    = 400;

	// what one result beat should carry
	typedef struct packed {
		status_t          status;
		logic [KEY_W-1:0] head_key;
		logic             head_tag;
		logic [CNT_W-1:0] occupancy;
		logic             is_empty;
	} queue_outcome_t;

	// one row of the directed table; typed rows carry their own answer
	typedef struct {
		action_t          action;
		logic [KEY_W-1:0] key;
		logic             tag;
		bit               typed;
		queue_outcome_t   outcome;
	} request_row_t;

	typedef enum int {
		READY_ALWAYS,
		READY_MOSTLY,
		READY_PERIODIC,
		READY_COIN
	} ready_style_t;

	localparam queue_outcome_t NO_FIXED = '0;

	logic clk;
	logic arst_n;

	sukq_req_if req_ch ();
	sukq_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

	sorted_unique_key_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the table, smallest key in slot 0
	logic [KEY_W-1:0] held_key [QDEPTH];
	logic             held_tag [QDEPTH];
	int               held_count;

	queue_outcome_t   pending_outcomes [$];
	request_row_t     script [N_DIRECTED];
	int               mismatches;
	int               outcomes_seen;
	int               cycle_count;
	int               burst_left;

	// apply one request to the shadow table and return the result it gives
	function automatic queue_outcome_t apply_request(action_t act, logic [KEY_W-1:0] k,
		logic t);
		queue_outcome_t o;
		int             pos;
		bit             dup;
		o = NO_FIXED;
		o.status = ST_OK;
		pos = 0;
		dup = 1'b0;
		case (act)
			ACT_PUSH: begin
				for (int i = 0; i < held_count; i++) begin
					if (held_key[i] == k)
						dup = 1'b1;
					if (held_key[i] < k)
						pos = i + 1;
				end
				// duplicate wins over full
				if (dup)
					o.status = ST_DUP;
				else if (held_count >= QDEPTH)
					o.status = ST_FULL;
				else begin
					for (int i = held_count; i > pos; i--) begin
						held_key[i] = held_key[i-1];
						held_tag[i] = held_tag[i-1];
					end
					held_key[pos] = k;
					held_tag[pos] = t;
					held_count++;
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (held_count == 0)
					o.status = ST_EMPTY;
				else begin
					o.head_key = held_key[0];
					o.head_tag = held_tag[0];
					if (act == ACT_POP) begin
						for (int i = 0; i + 1 < held_count; i++) begin
							held_key[i] = held_key[i+1];
							held_tag[i] = held_tag[i+1];
						end
						held_count--;
					end
				end
			end
			default: ;
		endcase
		o.occupancy = held_count[CNT_W-1:0];
		o.is_empty  = (held_count == 0);
		return o;
	endfunction

	// offer one request beat, wait for it to be taken, log what it should return
	task automatic send_request(action_t act, logic [KEY_W-1:0] k, logic t, bit typed,
		queue_outcome_t fixed);
		queue_outcome_t o;
		bit             taken;
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.key    <= k;
		req_ch.tag    <= t;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = req_ch.ready;
			@(posedge clk);
		end
		o = apply_request(act, k, t);
		pending_outcomes.push_back(typed ? fixed : o);
	endtask

	// sender works in bursts; between bursts a gap drops valid
	task automatic pace_sender();
		int gap;
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// reset, once
	initial begin
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_unique_key_queue_tb: done, errors");
			$finish;
		end
	end

	// receiver: changing ready styles, plus one long hold-off
	initial begin : drive_ready
		ready_style_t style;
		int           style_left;
		int           hold_left;
		bit           hold_done;
		int           tick;
		style      = READY_ALWAYS;
		style_left = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		tick       = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			tick++;
			if (!hold_done && outcomes_seen >= HOLD_AFTER) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					style      = ready_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(16, 96);
				end
				style_left--;
				case (style)
					READY_ALWAYS:   rsp_ch.ready <= 1'b1;
					READY_MOSTLY:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					READY_PERIODIC: rsp_ch.ready <= (tick % 3 != 0);
					default:        rsp_ch.ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// result check, sampled mid-cycle so the beat is settled
	initial begin
		mismatches    = 0;
		outcomes_seen = 0;
	end
	always @(negedge clk) begin : check_results
		queue_outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			outcomes_seen++;
			if (pending_outcomes.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.head_key !== want.head_key) begin
					$error("head_key: expected %h, got %h", want.head_key, rsp_ch.head_key);
					mismatches++;
				end
				if (rsp_ch.head_tag !== want.head_tag) begin
					$error("head_tag: expected %b, got %b", want.head_tag, rsp_ch.head_tag);
					mismatches++;
				end
				if (rsp_ch.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						rsp_ch.occupancy);
					mismatches++;
				end
				if (rsp_ch.is_empty !== want.is_empty) begin
					$error("is_empty: expected %b, got %b", want.is_empty, rsp_ch.is_empty);
					mismatches++;
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		bit               fill_mode;
		int               mode_left;
		int               pick;
		int               len;
		action_t          act;
		logic [KEY_W-1:0] k;
		logic             t;

		held_count = 0;
		burst_left = 0;
		fill_mode  = 1'b1;
		mode_left  = 0;
		req_ch.valid  <= 1'b0;
		req_ch.action <= ACT_QUERY;
		req_ch.key    <= '0;
		req_ch.tag    <= 1'b0;

		// empty-queue cases, extremes, duplicate, ASCII order, fill to full
		script[0]  = '{ACT_PEEK, '0, 1'b0, 1'b1, '{ST_EMPTY, 64'h0, 1'b0, 5'd0, 1'b1}};
		script[1]  = '{ACT_POP, '1, 1'b1, 1'b1, '{ST_EMPTY, 64'h0, 1'b0, 5'd0, 1'b1}};
		script[2]  = '{ACT_QUERY, '0, 1'b0, 1'b1, '{ST_OK, 64'h0, 1'b0, 5'd0, 1'b1}};
		script[3]  = '{ACT_PUSH, '1, 1'b1, 1'b1, '{ST_OK, 64'h0, 1'b0, 5'd1, 1'b0}};
		script[4]  = '{ACT_PUSH, '0, 1'b0, 1'b1, '{ST_OK, 64'h0, 1'b0, 5'd2, 1'b0}};
		script[5]  = '{ACT_PUSH, '1, 1'b0, 1'b1, '{ST_DUP, 64'h0, 1'b0, 5'd2, 1'b0}};
		script[6]  = '{ACT_PUSH, 64'h424F_4200_0000_0000, 1'b0, 1'b0, NO_FIXED};
		script[7]  = '{ACT_PUSH, 64'h414C_4943_4500_0000, 1'b1, 1'b0, NO_FIXED};
		script[8]  = '{ACT_PUSH, 64'h414C_4900_0000_0000, 1'b1, 1'b0, NO_FIXED};
		script[9]  = '{ACT_PEEK, '1, 1'b1, 1'b0, NO_FIXED};
		script[10] = '{ACT_POP, '0, 1'b0, 1'b0, NO_FIXED};
		script[11] = '{ACT_PUSH, 64'h0000_0000_0000_0001, 1'b1, 1'b0, NO_FIXED};
		script[12] = '{ACT_PUSH, 64'h8000_0000_0000_0000, 1'b0, 1'b0, NO_FIXED};
		script[13] = '{ACT_PUSH, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, NO_FIXED};
		script[14] = '{ACT_PUSH, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, NO_FIXED};
		script[15] = '{ACT_PUSH, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 1'b0, NO_FIXED};
		script[16] = '{ACT_PUSH, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b0, NO_FIXED};
		script[17] = '{ACT_PUSH, 64'h4100_0000_0000_0000, 1'b1, 1'b0, NO_FIXED};
		script[18] = '{ACT_PUSH, 64'h414C_4943_4541_0000, 1'b0, 1'b0, NO_FIXED};
		script[19] = '{ACT_PUSH, 64'h5A00_0000_0000_0000, 1'b1, 1'b0, NO_FIXED};
		script[20] = '{ACT_PUSH, 64'h0000_0000_0000_0100, 1'b0, 1'b0, NO_FIXED};
		script[21] = '{ACT_PUSH, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, NO_FIXED};
		script[22] = '{ACT_PUSH, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, NO_FIXED};
		script[23] = '{ACT_PUSH, 64'h4341_524F_4C00_0000, 1'b1, 1'b1,
			'{ST_FULL, 64'h0, 1'b0, 5'd16, 1'b0}};
		script[24] = '{ACT_PUSH, 64'h424F_4200_0000_0000, 1'b1, 1'b1,
			'{ST_DUP, 64'h0, 1'b0, 5'd16, 1'b0}};

		wait (arst_n);
		@(posedge clk);

		for (int n = 0; n < N_DIRECTED; n++) begin
			send_request(script[n].action, script[n].key, script[n].tag, script[n].typed,
				script[n].outcome);
			pace_sender();
		end

		// random traffic, swinging between filling and draining phases
		for (int n = 0; n < N_RANDOM; n++) begin
			if (mode_left == 0) begin
				fill_mode = !fill_mode;
				mode_left = $urandom_range(20, 60);
			end
			mode_left--;

			pick = $urandom_range(0, 99);
			if (pick < (fill_mode ? 60 : 20))
				act = ACT_PUSH;
			else if (pick < 80)
				act = ACT_POP;
			else if (pick < 92)
				act = ACT_PEEK;
			else
				act = ACT_QUERY;

			k = {$urandom, $urandom};
			t = 1'($urandom_range(0, 1));
			if (act == ACT_PUSH) begin
				pick = $urandom_range(0, 9);
				if (pick < 3) begin
					// fully random key as drawn
				end else if (pick < 6) begin
					// short names over a tiny alphabet: collisions and shared prefixes
					len = $urandom_range(1, 8);
					k = '0;
					for (int b = 0; b < len; b++)
						k[KEY_W-1-8*b -: 8] = 8'(8'h41 + $urandom_range(0, 3));
				end else if (pick < 8 && held_count > 0)
					k = held_key[$urandom_range(0, held_count - 1)];
				else if (pick < 9)
					k = KEY_W'($urandom_range(0, 7));
				else begin
					case ($urandom_range(0, 3))
						0:       k = '0;
						1:       k = '1;
						2:       k = 64'h8000_0000_0000_0000;
						default: k = 64'hFFFF_FFFF_FFFF_FFFE;
					endcase
				end
			end

			// midway, let the block run dry before going on
			if (n == N_RANDOM / 2) begin
				req_ch.valid <= 1'b0;
				while (pending_outcomes.size() != 0)
					@(posedge clk);
			end

			send_request(act, k, t, 1'b0, NO_FIXED);
			pace_sender();
		end

		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_unique_key_queue_tb: done, clean");
		else
			$display("sorted_unique_key_queue_tb: done, errors");
		$finish;
	end

endmodule
